### hdl/assert_macros.svh
// Assertion macros shared by the trigger wheel generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TWPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define TWPG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/twpg_pkg.sv
// Shared types and constants of the trigger wheel pattern generator.
package twpg_pkg;

  // Pattern store geometry
  localparam int PATTERN_DEPTH = 1024;
  localparam int ADDR_W        = $clog2(PATTERN_DEPTH);
  localparam int LEN_W         = $clog2(PATTERN_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIRECTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALER      = 2'd2;

  localparam logic [10:0] RESET_LENGTH  = 11'd1;
  localparam logic [15:0] RESET_SCALER  = 16'd4096;
  localparam logic [15:0] RESET_COMPARE = 16'd5000;

  // Command codes
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SPEED = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_t;

  // Prescale codes
  localparam logic [2:0] PRESC_DIV1    = 3'd0;
  localparam logic [2:0] PRESC_DIV8    = 3'd1;
  localparam logic [2:0] PRESC_DIV64   = 3'd2;
  localparam logic [2:0] PRESC_DIV256  = 3'd3;
  localparam logic [2:0] PRESC_DIV1024 = 3'd4;

  // Speed arithmetic: 8 MHz timer times 4096 scaler units
  localparam int                NUM_W       = 35;
  localparam logic [NUM_W-1:0]  DIVIDEND    = 35'd32768000000;
  localparam logic [15:0]       MIN_RPM     = 16'd10;
  localparam logic [NUM_W-1:0]  THRESH_8    = 35'd65536;
  localparam logic [NUM_W-1:0]  THRESH_64   = 35'd524288;
  localparam logic [NUM_W-1:0]  THRESH_256  = 35'd4194304;
  localparam logic [NUM_W-1:0]  THRESH_1024 = 35'd16777216;
  localparam logic [NUM_W-1:0]  COMPARE_MAX = 35'd65535;

  // Command word
  typedef struct packed {
    cmd_t        command;
    logic [9:0]  entry_address;
    logic [7:0]  entry_data;
    logic [15:0] speed_rpm;
  } twpg_cmd_t;

  // Result word
  typedef struct packed {
    logic [7:0]  pin_byte;
    logic [15:0] compare_value;
    logic [2:0]  prescale_select;
  } twpg_res_t;

  // Speed unit status toward the sequencer
  typedef struct packed {
    logic        done;
    logic [15:0] compare;
    logic [2:0]  prescale;
  } twpg_speed_t;

endpackage

### hdl/trigger_wheel_pattern_generator_unit.sv
// Top level of the trigger wheel pattern generator: command sequencer and result register.
//
// Usage:
//   Commands enter on cmd_valid/cmd_ready, one word each: load a pattern byte, set a
//   speed, or tick. Only a tick gives a result word on res_valid/res_ready, carrying
//   the pin byte at the current edge, the compare value and the prescale in effect.
//   Configuration (pattern length, direction, speed scaler) is written through
//   cfg_write/cfg_index/cfg_data while no command is in flight.
// Sequence:
//   A load writes the pattern store when accepted. A tick passes the pattern memory read, then
//   the result register load; res_valid rises when the read stage finds the result register free.
//   A speed command passes the operand and product registers, then the 35-step bit-serial
//   divider and its finish state.
// Reset:
//   Position, pending compare (5000), prescale and configuration go to their reset
//   values. The pattern memory is not cleared; the user must load every entry before a tick
//   reads it, and the block does not enforce this.
// Stall:
//   A result word holds until taken. A new command is accepted while it waits; a
//   following tick holds in its read stage until the result register is free.
`include "assert_macros.svh"

module trigger_wheel_pattern_generator_unit
  import twpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  twpg_cmd_t             cmd,
  output logic                  res_valid,
  input  logic                  res_ready,
  output twpg_res_t             res
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_SPEED = 3'b100
  } seq_state_t;

  seq_state_t        state;
  logic [10:0]       pattern_length;
  logic              reverse_direction;
  logic [15:0]       speed_scaler;
  logic [ADDR_W-1:0] edge_position;
  logic [15:0]       pending_compare;
  logic [2:0]        pending_prescale;
  logic              prescale_update_flag;
  logic [2:0]        active_prescale;

  logic              accept;
  logic              load_acc;
  logic              speed_acc;
  logic              tick_acc;
  logic              res_load;
  logic              ram_we;
  logic [7:0]        ram_rdata;
  logic [LEN_W-1:0]  len_eff;
  logic [ADDR_W-1:0] pos_cur;
  logic [LEN_W-1:0]  pos_inc;
  logic [ADDR_W-1:0] pos_fwd;
  logic [ADDR_W-1:0] pos_bwd;
  logic [ADDR_W-1:0] edge_position_next;
  twpg_speed_t       spd;

  // Decode accepted commands
  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign load_acc  = accept && (cmd.command == CMD_LOAD);
  assign speed_acc = accept && (cmd.command == CMD_SPEED);
  assign tick_acc  = accept && (cmd.command == CMD_TICK);
  assign ram_we    = load_acc && (32'(cmd.entry_address) < PATTERN_DEPTH);
  assign res_load  = (state == S_READ) && (!res_valid || res_ready);

  // Clamp the pattern length to the range from one to the store depth
  always_comb begin
    priority if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(pattern_length) > PATTERN_DEPTH) begin
      len_eff = LEN_W'(PATTERN_DEPTH);
    end else begin
      len_eff = LEN_W'(pattern_length);
    end
  end

  // Current edge and its successor in either direction
  assign pos_cur = (LEN_W'(edge_position) >= len_eff) ? '0 : edge_position;
  assign pos_inc = LEN_W'(pos_cur) + LEN_W'(1);
  assign pos_fwd = (pos_inc == len_eff) ? '0 : ADDR_W'(pos_inc);
  assign pos_bwd = (pos_cur == '0) ? ADDR_W'(len_eff - LEN_W'(1)) : pos_cur - ADDR_W'(1);
  assign edge_position_next = reverse_direction ? pos_bwd : pos_fwd;

  // Pattern store
  twpg_ram #(
    .WIDTH(8),
    .DEPTH(PATTERN_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ADDR_W'(cmd.entry_address)),
    .wdata(cmd.entry_data),
    .re   (tick_acc),
    .raddr(pos_cur),
    .rdata(ram_rdata)
  );

  // Speed unit
  twpg_speed u_speed (
    .clk   (clk),
    .rst   (rst),
    .start (speed_acc),
    .rpm   (cmd.speed_rpm),
    .scaler(speed_scaler),
    .res   (spd)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length    <= RESET_LENGTH;
      reverse_direction <= 1'b0;
      speed_scaler      <= RESET_SCALER;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH:    pattern_length    <= cfg_data[10:0];
        REG_REVERSE_DIRECTION: reverse_direction <= cfg_data[0];
        REG_SPEED_SCALER:      speed_scaler      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer, wheel position and timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      edge_position        <= '0;
      pending_compare      <= RESET_COMPARE;
      pending_prescale     <= PRESC_DIV1;
      prescale_update_flag <= 1'b0;
      active_prescale      <= PRESC_DIV1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (tick_acc) begin
            state         <= S_READ;
            edge_position <= edge_position_next;
            if (prescale_update_flag) begin
              active_prescale      <= pending_prescale;
              prescale_update_flag <= 1'b0;
            end
          end else if (speed_acc) begin
            state <= S_SPEED;
          end
        end
        S_READ: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        S_SPEED: begin
          if (spd.done) begin
            pending_compare      <= spd.compare;
            pending_prescale     <= spd.prescale;
            prescale_update_flag <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register: load from the read stage, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.pin_byte        <= ram_rdata;
      res.compare_value   <= pending_compare;
      res.prescale_select <= active_prescale;
    end
  end

  `TWPG_ASSERT(a_res_from_read, $rose(res_valid) |-> $past(state == S_READ), "result word without a tick read")
  `TWPG_ASSERT_ALWAYS(a_speed_done_state, spd.done |-> (state == S_SPEED || rst), "speed unit finished outside a speed command")
  `TWPG_ASSERT(a_tick_applies_prescale, $past(tick_acc) |-> !prescale_update_flag, "pending prescale not applied on tick")
  `TWPG_ASSERT(a_no_write_in_read, (state == S_READ) |-> !ram_we, "pattern store written during a tick read")

endmodule

### hdl/twpg_ram.sv
// Generic single write, single read RAM with registered read data.
module twpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/twpg_speed.sv
// Speed unit: rpm to timer compare value and prescale, by a bit-serial divider.
`include "assert_macros.svh"

module twpg_speed
  import twpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] rpm,
  input  logic [15:0] scaler,
  output twpg_speed_t res
);

  typedef enum logic [3:0] {
    SP_IDLE = 4'b0001,
    SP_MUL  = 4'b0010,
    SP_DIV  = 4'b0100,
    SP_FIN  = 4'b1000
  } sp_state_t;

  sp_state_t        state;
  logic [15:0]      op_rpm;
  logic [15:0]      op_scaler;
  logic [31:0]      divisor;
  logic [31:0]      rem;
  logic [NUM_W-1:0] nq;
  logic [5:0]       cnt;
  logic [32:0]      trial;
  logic             fits;
  logic [32:0]      diff;
  logic [NUM_W-1:0] scaled;
  logic [2:0]       sel;

  // Trial subtract of one divider step
  assign trial = {rem, nq[NUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SP_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        SP_IDLE: begin
          if (start) begin
            state <= SP_MUL;
          end
        end
        SP_MUL: begin
          state <= SP_DIV;
          cnt   <= 6'(NUM_W - 1);
        end
        SP_DIV: begin
          cnt <= cnt - 6'd1;
          if (cnt == '0) begin
            state <= SP_FIN;
          end
        end
        SP_FIN: begin
          state <= SP_IDLE;
        end
        default: begin
          state <= SP_IDLE;
        end
      endcase
    end
  end

  // Operands, product and divider datapath
  always_ff @(posedge clk) begin
    if (state == SP_IDLE && start) begin
      op_rpm    <= (rpm < MIN_RPM) ? MIN_RPM : rpm;
      op_scaler <= (scaler == '0) ? 16'd1 : scaler;
    end
    if (state == SP_MUL) begin
      divisor <= {16'b0, op_rpm} * {16'b0, op_scaler};
      rem     <= '0;
      nq      <= DIVIDEND;
    end
    if (state == SP_DIV) begin
      rem <= fits ? diff[31:0] : trial[31:0];
      nq  <= {nq[NUM_W-2:0], fits};
    end
  end

  // Pick prescale and shift the quotient to match
  always_comb begin
    priority if (nq >= THRESH_1024) begin
      sel    = PRESC_DIV1024;
      scaled = nq >> 10;
    end else if (nq >= THRESH_256) begin
      sel    = PRESC_DIV256;
      scaled = nq >> 8;
    end else if (nq >= THRESH_64) begin
      sel    = PRESC_DIV64;
      scaled = nq >> 6;
    end else if (nq >= THRESH_8) begin
      sel    = PRESC_DIV8;
      scaled = nq >> 3;
    end else begin
      sel    = PRESC_DIV1;
      scaled = nq;
    end
  end

  // Drive done in the finish state, the chosen prescale and the saturated compare value
  assign res.done     = (state == SP_FIN);
  assign res.prescale = sel;
  assign res.compare  = (scaled > COMPARE_MAX) ? 16'hFFFF : scaled[15:0];

  `TWPG_ASSERT(a_cnt_range, (state == SP_DIV) |-> (cnt < 6'(NUM_W)), "divider step count out of range")
  `TWPG_ASSERT(a_done_pulse, res.done |=> !res.done, "speed done held longer than one cycle")
  `TWPG_ASSERT(a_start_div, (state == SP_MUL) |=> (state == SP_DIV), "divider did not follow product")

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the trigger wheel pattern generator unit.
module tb;
  import twpg_pkg::*;

  localparam int IDLE_LIMIT    = 3000;  // cycles with no word moved before giving up
  localparam int SETTLE_CYCLES = 60;    // outlasts a speed command in flight
  localparam int LONG_HOLD     = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_ready;
  twpg_cmd_t             cmd = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  twpg_res_t             res;

  trigger_wheel_pattern_generator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Wheel state as the block should hold it
  logic [7:0]  wheel_mem [PATTERN_DEPTH];
  int unsigned wheel_pos;
  logic [15:0] pend_compare;
  logic [2:0]  pend_presc;
  bit          presc_update;
  logic [2:0]  active_presc;
  logic [10:0] wheel_len;
  bit          wheel_reverse;
  logic [15:0] wheel_scaler;

  twpg_res_t   pin_words_due [$];
  twpg_cmd_t   cmds_pending [$];
  bit          mem_loaded [PATTERN_DEPTH];
  int          issued_cnt = 0;
  int          accepted_cnt = 0;
  int          failures = 0;
  int          idle_pct = 0;
  int          long_hold_reqs = 0;

  function automatic int unsigned eff_length(logic [10:0] raw);
    if (raw == 11'd0) return 1;
    if (raw > PATTERN_DEPTH) return PATTERN_DEPTH;
    return raw;
  endfunction

  // Turn an rpm into the pending compare value and prescale
  function automatic void apply_speed(logic [15:0] rpm_in);
    longint unsigned rpm, scl, period;
    int shamt;
    rpm = (rpm_in < MIN_RPM) ? 64'(MIN_RPM) : 64'(rpm_in);
    scl = (wheel_scaler == 16'd0) ? 64'd1 : 64'(wheel_scaler);
    period = 64'd32768000000 / (scl * rpm);
    if (period >= 64'd16777216) begin
      pend_presc = PRESC_DIV1024;
      shamt = 10;
    end else if (period >= 64'd4194304) begin
      pend_presc = PRESC_DIV256;
      shamt = 8;
    end else if (period >= 64'd524288) begin
      pend_presc = PRESC_DIV64;
      shamt = 6;
    end else if (period >= 64'd65536) begin
      pend_presc = PRESC_DIV8;
      shamt = 3;
    end else begin
      pend_presc = PRESC_DIV1;
      shamt = 0;
    end
    period = period >> shamt;
    pend_compare = (period > 64'd65535) ? 16'hFFFF : period[15:0];
    presc_update = 1'b1;
  endfunction

  // Advance the wheel by one accepted command word
  function automatic void predict_command(twpg_cmd_t c);
    int unsigned len, pos;
    twpg_res_t r;
    case (c.command)
      CMD_LOAD:  wheel_mem[c.entry_address] = c.entry_data;
      CMD_SPEED: apply_speed(c.speed_rpm);
      CMD_TICK: begin
        len = eff_length(wheel_len);
        pos = (wheel_pos >= len) ? 0 : wheel_pos;
        r.pin_byte = wheel_mem[pos];
        if (!wheel_reverse) begin
          pos++;
          if (pos == len) pos = 0;
        end else begin
          if (pos == 0) pos = len;
          pos--;
        end
        wheel_pos = pos;
        if (presc_update) begin
          active_presc = pend_presc;
          presc_update = 1'b0;
        end
        r.compare_value   = pend_compare;
        r.prescale_select = active_presc;
        pin_words_due.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result(twpg_res_t got);
    twpg_res_t want;
    if (pin_words_due.size() == 0) begin
      $error("unexpected result word: pin_byte %0d compare_value %0d prescale_select %0d",
             got.pin_byte, got.compare_value, got.prescale_select);
      failures++;
      return;
    end
    want = pin_words_due.pop_front();
    if (got.pin_byte !== want.pin_byte) begin
      $error("pin_byte: expected %0d, got %0d", want.pin_byte, got.pin_byte);
      failures++;
    end
    if (got.compare_value !== want.compare_value) begin
      $error("compare_value: expected %0d, got %0d", want.compare_value, got.compare_value);
      failures++;
    end
    if (got.prescale_select !== want.prescale_select) begin
      $error("prescale_select: expected %0d, got %0d", want.prescale_select,
             got.prescale_select);
      failures++;
    end
  endfunction

  function automatic void queue_cmd(cmd_t op, logic [9:0] addr, logic [7:0] data,
                                    logic [15:0] rpm);
    twpg_cmd_t c;
    c.command       = op;
    c.entry_address = addr;
    c.entry_data    = data;
    c.speed_rpm     = rpm;
    if (op == CMD_LOAD) mem_loaded[addr] = 1'b1;
    cmds_pending.push_back(c);
    issued_cnt++;
  endfunction

  // Unused fields of a tick carry noise
  function automatic void queue_tick();
    queue_cmd(CMD_TICK, 10'($urandom), 8'($urandom), 16'($urandom));
  endfunction

  // Load every entry the next ticks can reach that has not been loaded yet
  function automatic void preload(int unsigned len, bit rev, int steps);
    int unsigned p;
    p = (wheel_pos >= len) ? 0 : wheel_pos;
    for (int i = 0; i <= steps; i++) begin
      if (!mem_loaded[p]) queue_cmd(CMD_LOAD, 10'(p), 8'($urandom), 16'($urandom));
      if (!rev) begin
        p++;
        if (p == len) p = 0;
      end else begin
        if (p == 0) p = len;
        p--;
      end
    end
  endfunction

  function automatic logic [15:0] random_rpm();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 12));
      1:       return 16'($urandom_range(13, 600));
      2:       return 16'($urandom_range(601, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void queue_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 14)
        queue_cmd(CMD_LOAD, 10'($urandom), 8'($urandom), 16'($urandom));
      else if (r < 24)
        queue_cmd(CMD_SPEED, 10'($urandom), 8'($urandom), random_rpm());
      else if (r < 27)
        queue_cmd(CMD_SPARE, 10'($urandom), 8'($urandom), 16'($urandom));
      else
        queue_tick();
    end
  endfunction

  // Wait until every word is taken and the block has gone quiet
  task automatic settle();
    while (accepted_cnt != issued_cnt || pin_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PATTERN_LENGTH:    wheel_len = val[10:0];
      REG_REVERSE_DIRECTION: wheel_reverse = val[0];
      REG_SPEED_SCALER:      wheel_scaler = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [10:0] len, bit rev, logic [15:0] scaler, int steps);
    settle();
    set_reg(REG_PATTERN_LENGTH, 16'(len));
    set_reg(REG_REVERSE_DIRECTION, 16'(rev));
    set_reg(REG_SPEED_SCALER, scaler);
    preload(eff_length(len), rev, steps);
  endtask

  task automatic run_phase(logic [10:0] len, bit rev, logic [15:0] scaler, int n,
                           int idle, bit long_hold);
    configure(len, rev, scaler, n);
    idle_pct = idle;
    if (long_hold) long_hold_reqs++;
    queue_random(n);
  endtask

  // Stimulus and end of run
  initial begin
    wheel_pos     = 0;
    pend_compare  = RESET_COMPARE;
    pend_presc    = PRESC_DIV1;
    presc_update  = 1'b0;
    active_presc  = PRESC_DIV1;
    wheel_len     = RESET_LENGTH;
    wheel_reverse = 1'b0;
    wheel_scaler  = RESET_SCALER;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: reset compare, spare code, rpm clamp, prescale applied once
    queue_cmd(CMD_LOAD, 10'd0, 8'hA5, 16'hFFFF);
    queue_tick();
    queue_cmd(CMD_SPARE, 10'h3FF, 8'hFF, 16'hFFFF);
    queue_tick();
    queue_cmd(CMD_SPEED, 10'd0, 8'd0, 16'd0);
    queue_tick();
    queue_cmd(CMD_SPEED, 10'd0, 8'd0, 16'hFFFF);
    queue_tick();
    queue_cmd(CMD_LOAD, 10'h3FF, 8'hFF, 16'd0);
    queue_cmd(CMD_LOAD, 10'd0, 8'h00, 16'd0);
    queue_cmd(CMD_SPEED, 10'd0, 8'd0, 16'd9);
    queue_cmd(CMD_SPEED, 10'd0, 8'd0, 16'd10);
    queue_tick();
    queue_tick();

    // zero length and zero scaler; slowest speed saturates the compare
    configure(11'd0, 1'b1, 16'd0, 2);
    queue_cmd(CMD_SPEED, 10'd0, 8'd0, 16'd10);
    queue_tick();
    queue_tick();

    // short wheel stepping backward across the wrap
    configure(11'd3, 1'b1, 16'd1, 4);
    queue_cmd(CMD_SPEED, 10'd0, 8'd0, 16'd1000);
    repeat (4) queue_tick();

    // random phases over several settings
    run_phase(11'd2, 1'b0, 16'd4096, 80, 30, 1'b0);
    run_phase(11'd7, 1'b1, 16'hFFFF, 80, 30, 1'b1);
    run_phase(11'd1, 1'b0, 16'd1, 60, 30, 1'b0);
    run_phase(11'd16, 1'b1, 16'($urandom_range(1, 65535)), 80, 0, 1'b0);
    run_phase(11'd5, 1'b0, 16'd2, 40, 30, 1'b0);
    // hold the sender until everything is back, then go on
    settle();
    queue_random(40);
    run_phase(11'd2047, 1'b1, 16'($urandom_range(1, 65535)), 80, 30, 1'b0);
    run_phase(11'd1024, 1'b0, 16'd8000, 60, 30, 1'b0);
    run_phase(11'($urandom_range(1, 64)), 1'($urandom), 16'($urandom), 80, 0, 1'b0);

    settle();
    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Command driver: present the next word, idle in bursts between words
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        predict_command(cmd);
        accepted_cnt++;
      end
      if (!cmd_valid || cmd_ready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          cmd_valid <= 1'b0;
        end else if (cmds_pending.size() != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
          send_gap  <= $urandom_range(0, 12);
          cmd_valid <= 1'b0;
        end else if (cmds_pending.size() != 0) begin
          cmd       <= cmds_pending.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each word taken, stall in bursts or one long stretch
  int hold_left = 0;
  int holds_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) check_result(res);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_ready <= 1'b0;
      end else if (holds_done != long_hold_reqs) begin
        holds_done <= holds_done + 1;
        hold_left  <= LONG_HOLD;
        res_ready  <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct / 3) begin
        hold_left <= $urandom_range(0, 12);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up after a long stretch with no word moved
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
